// ----- hdl/ecf_pkg.sv -----
// Shared types, constants and fixed-point helpers for the elastic chain follower.
// Used by ecf_stream_if, ecf_mul and the top level; depends on nothing.

package ecf_pkg;

    // Field widths.
    localparam int COORD_W    = 24;
    localparam int COEF_W     = 16;
    localparam int PIDX_W     = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Chain length default.
    localparam int POINTS_DEF = 16;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_SPRING_GAIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DAMPING_BASE = 2'd1;

    // Register reset values.
    localparam logic [COEF_W-1:0] SPRING_GAIN_RST  = 16'd3277;
    localparam logic [COEF_W-1:0] DAMPING_BASE_RST = 16'd62259;

    // Per-particle gain is floor((7 * spring_gain * (i+1) + 50) / 100), tracked
    // incrementally as a quotient and a remainder below 100.
    localparam int GAIN_W = 19;
    localparam int REM_W  = 7;
    localparam logic [REM_W-1:0] REM_START = 7'd50;
    localparam logic [REM_W:0]   REM_MOD   = 8'd100;
    localparam logic [GAIN_W-1:0] PCT_MUL  = 19'd100;

    // Damping offset is floor((131072 * i + 50) / 100) = 1310 * i plus a carry term.
    localparam int DOFF_W = 17;
    localparam logic [DOFF_W-1:0] DOFF_STEP_Q = 17'd1310;
    localparam logic [REM_W:0]    DOFF_STEP_R = 8'd72;

    // Reciprocal of 100 scaled by 2^32, rounded up; exact for operands below 2^25.
    localparam int RECIP_SH = 32;
    localparam logic [25:0] RECIP_100 = 26'd42949673;

    // Shared multiplier: signed A times unsigned B.
    localparam int MUL_A_W = 26;
    localparam int MUL_B_W = 26;
    localparam int PROD_W  = MUL_A_W + MUL_B_W + 1;

    // Intermediate sum width and Q0.16 rounding.
    localparam int SUM_W   = 29;
    localparam int FRAC_SH = 16;
    localparam logic signed [PROD_W-1:0] ROUND_HALF = 53'sd32768;

    typedef logic signed [COORD_W-1:0] coord_t;

    // One stored particle.
    typedef struct packed {
        coord_t px;
        coord_t py;
        coord_t vx;
        coord_t vy;
    } particle_t;

    // Clamp to the signed 24-bit range.
    function automatic coord_t sat_coord(input logic signed [SUM_W-1:0] v);
        coord_t r;
        if (v > SUM_W'(signed'(24'sh7FFFFF)))
            r = 24'sh7FFFFF;
        else if (v < -SUM_W'(signed'(25'sh0800000)))
            r = 24'sh800000;
        else
            r = v[COORD_W-1:0];
        return r;
    endfunction

    // Product divided by 2^16, rounding half toward plus infinity.
    function automatic logic signed [SUM_W-1:0] round_q16(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] t;
        t = p + ROUND_HALF;
        return t[FRAC_SH +: SUM_W];
    endfunction

    // Sign-extend a coordinate to the sum width.
    function automatic logic signed [SUM_W-1:0] ext_coord(input coord_t c);
        return {{(SUM_W-COORD_W){c[COORD_W-1]}}, c};
    endfunction

endpackage

// ----- hdl/ecf_stream_if.sv -----
// Valid/ready stream interfaces for target transactions and vertex transactions.
// Depends on ecf_pkg for the coordinate type.

interface ecf_target_if;
    logic            valid;
    logic            ready;
    ecf_pkg::coord_t target_x;
    ecf_pkg::coord_t target_y;
    ecf_pkg::coord_t depth_z;

    modport source (output valid, output target_x, output target_y, output depth_z,
                    input ready);
    modport sink   (input valid, input target_x, input target_y, input depth_z,
                    output ready);
endinterface

interface ecf_vertex_if;
    logic                        valid;
    logic                        ready;
    ecf_pkg::coord_t             vertex_x;
    ecf_pkg::coord_t             vertex_y;
    ecf_pkg::coord_t             vertex_z;
    logic [ecf_pkg::PIDX_W-1:0]  particle_index;
    logic                        is_last;

    modport source (output valid, output vertex_x, output vertex_y, output vertex_z,
                    output particle_index, output is_last, input ready);
    modport sink   (input valid, input vertex_x, input vertex_y, input vertex_z,
                    input particle_index, input is_last, output ready);
endinterface

// ----- hdl/ecf_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; depends on nothing.

module ecf_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ----- hdl/ecf_mul.sv -----
// Shared multiplier: signed operand A times unsigned operand B, product registered.
// Depends on ecf_pkg for operand widths.

module ecf_mul (
    input  logic                                  clk,
    input  logic                                  en,
    input  logic signed [ecf_pkg::MUL_A_W-1:0]    a,
    input  logic        [ecf_pkg::MUL_B_W-1:0]    b,
    output logic signed [ecf_pkg::PROD_W-1:0]     p
);

    logic signed [ecf_pkg::PROD_W-1:0] prod_reg;

    // The product holds while the unit is not enabled.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= a * $signed({1'b0, b});
        end
    end

    assign p = prod_reg;

endmodule

// ----- hdl/elastic_chain_follower_unit.sv -----
// Elastic chain follower top level: sequencer, particle store and output register.
// Depends on ecf_pkg, ecf_stream_if, ecf_ram and ecf_mul.

// Each target transaction walks the chain of POINTS particles in index order and
// gives one vertex transaction per particle, the last one flagged with is_last.
// Set-up states INIT1 and INIT2 split the gain step by 100 into a quotient and
// a remainder; each particle then passes READ (fetch its state), MX, MY, DX
// and DY on the single shared multiplier (pull in x and y, damping in x and y)
// and WR (write-back and emit, held until the output register is free). Target
// ready is high only between targets; the last vertex may still sit in the
// output register when the next target is taken. Configuration writes are
// meant for idle periods; particle state is cleared by reset.

module elastic_chain_follower_unit #(
    parameter int POINTS = ecf_pkg::POINTS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    ecf_target_if.sink                        target,
    ecf_vertex_if.source                      vertex,
    input  logic                              cfg_we,
    input  logic [ecf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ecf_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int IDX_W = $clog2(POINTS);
    localparam int WORD_W = $bits(ecf_pkg::particle_t);

    // Sequencer states.
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_INIT1 = 4'd1;
    localparam logic [3:0] ST_INIT2 = 4'd2;
    localparam logic [3:0] ST_READ  = 4'd3;
    localparam logic [3:0] ST_MX    = 4'd4;
    localparam logic [3:0] ST_MY    = 4'd5;
    localparam logic [3:0] ST_DX    = 4'd6;
    localparam logic [3:0] ST_DY    = 4'd7;
    localparam logic [3:0] ST_WR    = 4'd8;

    // Control state.
    logic [3:0]                       state_reg, state_next;
    logic [IDX_W-1:0]                 idx_reg, idx_next;
    logic [POINTS-1:0]                valid_reg, valid_next;
    logic [ecf_pkg::COEF_W-1:0]       sg_reg, sg_next;
    logic [ecf_pkg::COEF_W-1:0]       db_reg, db_next;
    logic                             ov_reg, ov_next;

    // Working registers.
    ecf_pkg::coord_t                  ax_reg, ax_next;
    ecf_pkg::coord_t                  ay_reg, ay_next;
    ecf_pkg::coord_t                  z_reg, z_next;
    ecf_pkg::coord_t                  px_reg, px_next;
    ecf_pkg::coord_t                  py_reg, py_next;
    ecf_pkg::coord_t                  vx_reg, vx_next;
    ecf_pkg::coord_t                  vy_reg, vy_next;
    logic [ecf_pkg::GAIN_W-1:0]       step_reg, step_next;
    logic [ecf_pkg::GAIN_W-1:0]       qs_reg, qs_next;
    logic [ecf_pkg::REM_W-1:0]        rs_reg, rs_next;
    logic [ecf_pkg::GAIN_W-1:0]       gq_reg, gq_next;
    logic [ecf_pkg::REM_W-1:0]        gr_reg, gr_next;
    logic [ecf_pkg::DOFF_W-1:0]       dq_reg, dq_next;
    logic [ecf_pkg::REM_W-1:0]        dr_reg, dr_next;
    logic                             hit_reg, hit_next;

    // Output register payload.
    ecf_pkg::coord_t                  ox_reg, ox_next;
    ecf_pkg::coord_t                  oy_reg, oy_next;
    ecf_pkg::coord_t                  oz_reg, oz_next;
    logic [ecf_pkg::PIDX_W-1:0]       oidx_reg, oidx_next;
    logic                             olast_reg, olast_next;

    // Datapath signals.
    logic [WORD_W-1:0]                rd_data;
    ecf_pkg::particle_t               cur;
    ecf_pkg::particle_t               wr_word;
    logic                             ram_we;
    logic                             mul_en;
    logic signed [ecf_pkg::MUL_A_W-1:0] mul_a;
    logic        [ecf_pkg::MUL_B_W-1:0] mul_b;
    logic signed [ecf_pkg::PROD_W-1:0]  prod;
    logic signed [ecf_pkg::COORD_W:0] diff_x, diff_y;
    logic [ecf_pkg::REM_W:0]          gsum, dsum;
    logic                             gcarry, dcarry;
    logic [ecf_pkg::DOFF_W:0]         damp_diff;
    logic [ecf_pkg::COEF_W-1:0]       damp;
    logic signed [ecf_pkg::SUM_W-1:0] pull;
    ecf_pkg::coord_t                  vel_upd, pos_upd, vel_damped;
    logic [ecf_pkg::GAIN_W-1:0]       qs_calc;
    logic [ecf_pkg::GAIN_W-1:0]       rs_calc;
    logic                             out_free;
    logic                             is_last_p;

    // Particle store.
    ecf_ram #(
        .WIDTH (WORD_W),
        .DEPTH (POINTS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (wr_word),
        .raddr (idx_reg),
        .rdata (rd_data)
    );

    // Shared multiplier.
    ecf_mul u_mul (
        .clk (clk),
        .en  (mul_en),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    // A particle never written since reset reads as all zero.
    assign cur = hit_reg ? ecf_pkg::particle_t'(rd_data) : '0;

    // Incremental gain and damping-offset tracking.
    assign gsum   = {1'b0, gr_reg} + {1'b0, rs_reg};
    assign gcarry = (gsum >= ecf_pkg::REM_MOD);
    assign dsum   = {1'b0, dr_reg} + ecf_pkg::DOFF_STEP_R;
    assign dcarry = (dsum >= ecf_pkg::REM_MOD);

    // Damping factor saturates at zero.
    assign damp_diff = {2'b00, db_reg} - {1'b0, dq_reg};
    assign damp      = damp_diff[ecf_pkg::DOFF_W] ? '0 : damp_diff[ecf_pkg::COEF_W-1:0];

    // Gain step split into quotient and remainder by 100.
    assign qs_calc = prod[ecf_pkg::RECIP_SH +: ecf_pkg::GAIN_W];
    assign rs_calc = step_reg - qs_calc * ecf_pkg::PCT_MUL;

    // Pulls toward the anchor.
    assign diff_x = {ax_reg[ecf_pkg::COORD_W-1], ax_reg} - {cur.px[ecf_pkg::COORD_W-1], cur.px};
    assign diff_y = {ay_reg[ecf_pkg::COORD_W-1], ay_reg} - {py_reg[ecf_pkg::COORD_W-1], py_reg};

    // Shared velocity and position update, used for x in MY and for y in DX.
    assign pull       = ecf_pkg::round_q16(prod);
    assign vel_upd    = ecf_pkg::sat_coord(pull + ecf_pkg::ext_coord((state_reg == ST_MY) ? vx_reg
                                                                                           : vy_reg));
    assign pos_upd    = ecf_pkg::sat_coord(ecf_pkg::ext_coord((state_reg == ST_MY) ? px_reg : py_reg)
                                           + ecf_pkg::ext_coord(vel_upd));
    assign vel_damped = ecf_pkg::sat_coord(pull);

    assign out_free  = !ov_reg || vertex.ready;
    assign is_last_p = (idx_reg == IDX_W'(POINTS - 1));
    assign ram_we    = (state_reg == ST_WR) && out_free;

    always_comb
    begin
        wr_word.px = px_reg;
        wr_word.py = py_reg;
        wr_word.vx = vx_reg;
        wr_word.vy = vel_damped;
    end

    // Multiplier operand selection.
    always_comb
    begin
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
        case (state_reg)
            ST_INIT1:
            begin
                mul_en = 1'b1;
                mul_a  = $signed({{(ecf_pkg::MUL_A_W-ecf_pkg::GAIN_W){1'b0}}, step_reg});
                mul_b  = ecf_pkg::RECIP_100;
            end
            ST_MX:
            begin
                mul_en = 1'b1;
                mul_a  = {diff_x[ecf_pkg::COORD_W], diff_x};
                mul_b  = ecf_pkg::MUL_B_W'(gq_reg);
            end
            ST_MY:
            begin
                mul_en = 1'b1;
                mul_a  = {diff_y[ecf_pkg::COORD_W], diff_y};
                mul_b  = ecf_pkg::MUL_B_W'(gq_reg);
            end
            ST_DX:
            begin
                mul_en = 1'b1;
                mul_a  = {{2{vx_reg[ecf_pkg::COORD_W-1]}}, vx_reg};
                mul_b  = ecf_pkg::MUL_B_W'(damp);
            end
            ST_DY:
            begin
                mul_en = 1'b1;
                mul_a  = {{2{vy_reg[ecf_pkg::COORD_W-1]}}, vy_reg};
                mul_b  = ecf_pkg::MUL_B_W'(damp);
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    // Sequencer and next-state logic.
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        valid_next = valid_reg;
        sg_next    = sg_reg;
        db_next    = db_reg;
        ov_next    = ov_reg;
        ax_next    = ax_reg;
        ay_next    = ay_reg;
        z_next     = z_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        vx_next    = vx_reg;
        vy_next    = vy_reg;
        step_next  = step_reg;
        qs_next    = qs_reg;
        rs_next    = rs_reg;
        gq_next    = gq_reg;
        gr_next    = gr_reg;
        dq_next    = dq_reg;
        dr_next    = dr_reg;
        hit_next   = hit_reg;
        ox_next    = ox_reg;
        oy_next    = oy_reg;
        oz_next    = oz_reg;
        oidx_next  = oidx_reg;
        olast_next = olast_reg;

        // Configuration writes.
        if (cfg_we)
        begin
            case (cfg_index)
                ecf_pkg::REG_SPRING_GAIN:  sg_next = cfg_data;
                ecf_pkg::REG_DAMPING_BASE: db_next = cfg_data;
                default:                   sg_next = sg_reg;
            endcase
        end

        // A pending vertex transaction leaves when taken.
        if (vertex.ready)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (target.valid)
                begin
                    ax_next    = target.target_x;
                    ay_next    = target.target_y;
                    z_next     = target.depth_z;
                    step_next  = {sg_reg, 3'b000} - ecf_pkg::GAIN_W'(sg_reg);
                    idx_next   = '0;
                    dq_next    = '0;
                    dr_next    = ecf_pkg::REM_START;
                    state_next = ST_INIT1;
                end
            end
            ST_INIT1:
            begin
                state_next = ST_INIT2;
            end
            ST_INIT2:
            begin
                qs_next    = qs_calc;
                rs_next    = rs_calc[ecf_pkg::REM_W-1:0];
                gq_next    = '0;
                gr_next    = ecf_pkg::REM_START;
                state_next = ST_READ;
            end
            ST_READ:
            begin
                gq_next    = gq_reg + qs_reg + ecf_pkg::GAIN_W'(gcarry);
                gr_next    = gcarry ? ecf_pkg::REM_W'(gsum - ecf_pkg::REM_MOD)
                                    : gsum[ecf_pkg::REM_W-1:0];
                hit_next   = valid_reg[idx_reg];
                state_next = ST_MX;
            end
            ST_MX:
            begin
                px_next    = cur.px;
                py_next    = cur.py;
                vx_next    = cur.vx;
                vy_next    = cur.vy;
                state_next = ST_MY;
            end
            ST_MY:
            begin
                vx_next    = vel_upd;
                px_next    = pos_upd;
                state_next = ST_DX;
            end
            ST_DX:
            begin
                vy_next    = vel_upd;
                py_next    = pos_upd;
                state_next = ST_DY;
            end
            ST_DY:
            begin
                vx_next    = vel_damped;
                state_next = ST_WR;
            end
            ST_WR:
            begin
                if (out_free)
                begin
                    valid_next[idx_reg] = 1'b1;
                    ov_next    = 1'b1;
                    ox_next    = px_reg;
                    oy_next    = py_reg;
                    oz_next    = z_reg;
                    oidx_next  = ecf_pkg::PIDX_W'(idx_reg);
                    olast_next = is_last_p;
                    ax_next    = px_reg;
                    ay_next    = py_reg;
                    dq_next    = dq_reg + ecf_pkg::DOFF_STEP_Q + ecf_pkg::DOFF_W'(dcarry);
                    dr_next    = dcarry ? ecf_pkg::REM_W'(dsum - ecf_pkg::REM_MOD)
                                        : dsum[ecf_pkg::REM_W-1:0];
                    if (is_last_p)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            valid_reg <= '0;
            sg_reg    <= ecf_pkg::SPRING_GAIN_RST;
            db_reg    <= ecf_pkg::DAMPING_BASE_RST;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
            sg_reg    <= sg_next;
            db_reg    <= db_next;
            ov_reg    <= ov_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        ax_reg    <= ax_next;
        ay_reg    <= ay_next;
        z_reg     <= z_next;
        px_reg    <= px_next;
        py_reg    <= py_next;
        vx_reg    <= vx_next;
        vy_reg    <= vy_next;
        step_reg  <= step_next;
        qs_reg    <= qs_next;
        rs_reg    <= rs_next;
        gq_reg    <= gq_next;
        gr_reg    <= gr_next;
        dq_reg    <= dq_next;
        dr_reg    <= dr_next;
        hit_reg   <= hit_next;
        ox_reg    <= ox_next;
        oy_reg    <= oy_next;
        oz_reg    <= oz_next;
        oidx_reg  <= oidx_next;
        olast_reg <= olast_next;
    end

    // Stream ports.
    assign target.ready          = (state_reg == ST_IDLE);
    assign vertex.valid          = ov_reg;
    assign vertex.vertex_x       = ox_reg;
    assign vertex.vertex_y       = oy_reg;
    assign vertex.vertex_z       = oz_reg;
    assign vertex.particle_index = oidx_reg;
    assign vertex.is_last        = olast_reg;

endmodule
